// File: hw/rtl/tcaa_pkg.sv
// Shared types, widths and constants of the triangle check and angle engine.
package tcaa_pkg;

   localparam int SIDE_BITS       = 16;
   localparam int ANGLE_FRAC_BITS = 14;
   localparam int ANGLE_BITS      = 16;

   localparam int MAG_BITS = SIDE_BITS - 1;
   localparam int SQ_BITS  = 2 * MAG_BITS;
   localparam int DEN_BITS = SQ_BITS + 1;
   localparam int NUM_BITS = SQ_BITS + 2;

   localparam int COS_FRAC     = 30;
   localparam int DIV_STEPS    = COS_FRAC;
   localparam int COS_BITS     = COS_FRAC + 1;
   localparam int CSQ_BITS     = 2 * COS_BITS;
   localparam int RAD_BITS     = 2 * COS_FRAC + 1;
   localparam int RES_BITS     = 2 * COS_FRAC + 2;
   localparam int SQRT_STEPS   = COS_FRAC + 1;
   localparam int CORDIC_STEPS = 32;
   localparam int XY_BITS      = COS_FRAC + 4;
   localparam int ANG_SHIFT    = COS_FRAC - ANGLE_FRAC_BITS;

   localparam int ANGLE_LAT = 7 + DIV_STEPS + SQRT_STEPS + CORDIC_STEPS;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef struct packed {
      logic signed [SIDE_BITS-1:0] side_a;
      logic signed [SIDE_BITS-1:0] side_b;
      logic signed [SIDE_BITS-1:0] side_c;
   } req_word_type;

   typedef struct packed {
      logic                  valid_res;
      logic [ANGLE_BITS-1:0] angle_a;
      logic [ANGLE_BITS-1:0] angle_b;
      logic [ANGLE_BITS-1:0] angle_c;
   } rsp_word_type;

   typedef struct packed {
      logic                ok;
      logic [MAG_BITS-1:0] a;
      logic [MAG_BITS-1:0] b;
      logic [MAG_BITS-1:0] c;
   } tri_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Arc tangent of 2^-i in Q30, rounded to nearest.
   function automatic logic signed [XY_BITS-1:0] atan_q30(input int i);
      logic [63:0] v;
      unique case (i)
         0:       v = 64'd843314857;
         1:       v = 64'd497837829;
         2:       v = 64'd263043837;
         3:       v = 64'd133525159;
         4:       v = 64'd67021687;
         5:       v = 64'd33543516;
         6:       v = 64'd16775851;
         7:       v = 64'd8388437;
         8:       v = 64'd4194283;
         9:       v = 64'd2097149;
         31:      v = 64'd1;
         default: v = 64'd1 << (COS_FRAC - i);
      endcase
      return XY_BITS'(v);
   endfunction

endpackage

// File: hw/rtl/tcaa_front.sv
// Front end: accepts side words, checks the triangle and hands it to the queue.
module tcaa_front import tcaa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_word_type     req_word,
   input  queue_status_type q_stat,
   output logic             push,
   output tri_type          push_ent
);

   logic    vld_ff, vld_in;
   tri_type ent_ff, ent_in;
   logic    accept;

   assign req_stall = vld_ff && q_stat.full;
   assign push      = vld_ff && !q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign push_ent  = ent_ff;

   always_comb begin
      logic [MAG_BITS:0] ab, ac, bc;
      logic              nonneg;
      ent_in.a = req_word.side_a[MAG_BITS-1:0];
      ent_in.b = req_word.side_b[MAG_BITS-1:0];
      ent_in.c = req_word.side_c[MAG_BITS-1:0];
      ab = {1'b0, ent_in.a} + {1'b0, ent_in.b};
      ac = {1'b0, ent_in.a} + {1'b0, ent_in.c};
      bc = {1'b0, ent_in.b} + {1'b0, ent_in.c};
      nonneg = !req_word.side_a[SIDE_BITS-1] && !req_word.side_b[SIDE_BITS-1] &&
               !req_word.side_c[SIDE_BITS-1];
      ent_in.ok = nonneg && (ab > {1'b0, ent_in.c}) && (ac > {1'b0, ent_in.b}) &&
                  (bc > {1'b0, ent_in.a});
   end

   always_comb begin
      vld_in = vld_ff;
      if (accept) begin
         vld_in = 1'b1;
      end else if (push) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (accept) begin
         ent_ff <= ent_in;
      end
   end

endmodule

// File: hw/rtl/tcaa_queue.sv
// Short queue that decouples the front end from the angle pipeline.
module tcaa_queue import tcaa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tri_type          push_ent,
   input  logic             pop,
   output tri_type          head,
   output queue_status_type q_stat
);

   tri_type              mem [0:QUEUE_DEPTH-1];
   logic [QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_BITS:0]   cnt_ff, cnt_in;

   assign head         = mem[rd_ff];
   assign q_stat.full  = (cnt_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem[wr_ff] <= push_ent;
      end
   end

endmodule

// File: hw/rtl/tcaa_angle.sv
// One angle lane: law of cosines, restoring divide, square root and CORDIC.
module tcaa_angle import tcaa_pkg::*; (
   input  logic                  clock,
   input  logic                  en,
   input  logic [MAG_BITS-1:0]   s,
   input  logic [MAG_BITS-1:0]   p,
   input  logic [MAG_BITS-1:0]   q,
   output logic [ANGLE_BITS-1:0] angle
);

   localparam logic [63:0] ANG_ROUND = (64'd1 << ANG_SHIFT) >> 1;

   function automatic logic signed [XY_BITS-1:0] shr_tz(
      input logic signed [XY_BITS-1:0] v, input int sh);
      logic signed [XY_BITS-1:0] m;
      m = -v;
      return v[XY_BITS-1] ? -(m >>> sh) : (v >>> sh);
   endfunction

   // Products.
   logic [SQ_BITS-1:0] ss_ff, pp_ff, qq_ff, pq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ss_ff <= SQ_BITS'(s) * SQ_BITS'(s);
         pp_ff <= SQ_BITS'(p) * SQ_BITS'(p);
         qq_ff <= SQ_BITS'(q) * SQ_BITS'(q);
         pq_ff <= SQ_BITS'(p) * SQ_BITS'(q);
      end
   end

   // Numerator, denominator and the long division, one quotient bit a stage.
   logic [DEN_BITS-1:0]  div_rem_ff [0:DIV_STEPS];
   logic [DEN_BITS-1:0]  div_den_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] div_q_ff   [0:DIV_STEPS];
   logic                 div_neg_ff [0:DIV_STEPS];
   logic                 div_sat_ff [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      logic signed [NUM_BITS-1:0] num;
      logic        [NUM_BITS-1:0] mag;
      logic        [DEN_BITS-1:0] den;
      num = $signed({2'b00, pp_ff}) + $signed({2'b00, qq_ff}) - $signed({2'b00, ss_ff});
      mag = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
      den = {pq_ff, 1'b0};
      if (en) begin
         div_rem_ff[0] <= mag[DEN_BITS-1:0];
         div_den_ff[0] <= den;
         div_q_ff[0]   <= '0;
         div_neg_ff[0] <= num[NUM_BITS-1];
         div_sat_ff[0] <= (mag >= {1'b0, den});
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [DEN_BITS:0] rem2, dif;
      logic              ge;
      assign rem2 = {div_rem_ff[k], 1'b0};
      assign dif  = rem2 - {1'b0, div_den_ff[k]};
      assign ge   = rem2 >= {1'b0, div_den_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            div_rem_ff[k+1] <= ge ? dif[DEN_BITS-1:0] : rem2[DEN_BITS-1:0];
            div_den_ff[k+1] <= div_den_ff[k];
            div_q_ff[k+1]   <= {div_q_ff[k][DIV_STEPS-2:0], ge};
            div_neg_ff[k+1] <= div_neg_ff[k];
            div_sat_ff[k+1] <= div_sat_ff[k];
         end
      end
   end

   // Rounded cosine magnitude in Q30, its square, then the radicand.
   logic [COS_BITS-1:0] c_ff;
   logic                c_neg_ff;
   logic [CSQ_BITS-1:0] csq_ff;
   logic [COS_BITS-1:0] csq_c_ff;
   logic                csq_neg_ff;

   always_ff @(posedge clock) begin
      logic rnd;
      rnd = {div_rem_ff[DIV_STEPS], 1'b0} >= {1'b0, div_den_ff[DIV_STEPS]};
      if (en) begin
         c_ff       <= div_sat_ff[DIV_STEPS] ? (COS_BITS'(1) << COS_FRAC) :
                       ({1'b0, div_q_ff[DIV_STEPS]} + COS_BITS'(rnd));
         c_neg_ff   <= div_neg_ff[DIV_STEPS];
         csq_ff     <= CSQ_BITS'(c_ff) * CSQ_BITS'(c_ff);
         csq_c_ff   <= c_ff;
         csq_neg_ff <= c_neg_ff;
      end
   end

   // Square root, two radicand bits a stage.
   logic [RAD_BITS-1:0] sq_v_ff   [0:SQRT_STEPS];
   logic [RES_BITS-1:0] sq_res_ff [0:SQRT_STEPS];
   logic [COS_BITS-1:0] sq_c_ff   [0:SQRT_STEPS];
   logic                sq_neg_ff [0:SQRT_STEPS];

   always_ff @(posedge clock) begin
      logic [CSQ_BITS-1:0] rad;
      rad = (CSQ_BITS'(1) << (2 * COS_FRAC)) - csq_ff;
      if (en) begin
         sq_v_ff[0]   <= rad[RAD_BITS-1:0];
         sq_res_ff[0] <= '0;
         sq_c_ff[0]   <= csq_c_ff;
         sq_neg_ff[0] <= csq_neg_ff;
      end
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      logic [RES_BITS-1:0] bitv, trial;
      logic                ge;
      assign bitv  = RES_BITS'(1) << (2 * COS_FRAC - 2 * j);
      assign trial = sq_res_ff[j] + bitv;
      assign ge    = {1'b0, sq_v_ff[j]} >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            sq_v_ff[j+1]   <= ge ? (sq_v_ff[j] - trial[RAD_BITS-1:0]) : sq_v_ff[j];
            sq_res_ff[j+1] <= ge ? ((sq_res_ff[j] >> 1) + bitv) : (sq_res_ff[j] >> 1);
            sq_c_ff[j+1]   <= sq_c_ff[j];
            sq_neg_ff[j+1] <= sq_neg_ff[j];
         end
      end
   end

   // CORDIC vectoring, one rotation a stage.
   logic signed [XY_BITS-1:0] cor_x_ff   [0:CORDIC_STEPS];
   logic signed [XY_BITS-1:0] cor_y_ff   [0:CORDIC_STEPS];
   logic signed [XY_BITS-1:0] cor_z_ff   [0:CORDIC_STEPS];
   logic                      cor_neg_ff [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         cor_x_ff[0]   <= $signed(XY_BITS'(sq_c_ff[SQRT_STEPS]));
         cor_y_ff[0]   <= $signed(XY_BITS'(sq_res_ff[SQRT_STEPS]));
         cor_z_ff[0]   <= '0;
         cor_neg_ff[0] <= sq_neg_ff[SQRT_STEPS];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [XY_BITS-1:0] xs, ys;
      logic                      ypos;
      assign xs   = shr_tz(cor_x_ff[i], i);
      assign ys   = shr_tz(cor_y_ff[i], i);
      assign ypos = !cor_y_ff[i][XY_BITS-1] && (cor_y_ff[i] != '0);
      always_ff @(posedge clock) begin
         if (en) begin
            cor_x_ff[i+1]   <= ypos ? cor_x_ff[i] + ys : cor_x_ff[i] - ys;
            cor_y_ff[i+1]   <= ypos ? cor_y_ff[i] - xs : cor_y_ff[i] + xs;
            cor_z_ff[i+1]   <= ypos ? cor_z_ff[i] + atan_q30(i) : cor_z_ff[i] - atan_q30(i);
            cor_neg_ff[i+1] <= cor_neg_ff[i];
         end
      end
   end

   // Fold for an obtuse angle, clamp to [0, pi], round to the output format.
   logic [ANGLE_BITS-1:0] angle_ff;

   always_ff @(posedge clock) begin
      logic signed [XY_BITS-1:0] pi_v, ang, cl;
      logic        [XY_BITS:0]   rsum, rsh;
      pi_v = $signed(XY_BITS'(PI_Q30));
      ang  = cor_neg_ff[CORDIC_STEPS] ? pi_v - cor_z_ff[CORDIC_STEPS] :
             cor_z_ff[CORDIC_STEPS];
      cl   = ang;
      if (ang[XY_BITS-1]) begin
         cl = '0;
      end else if (ang > pi_v) begin
         cl = pi_v;
      end
      rsum = {1'b0, cl} + (XY_BITS+1)'(ANG_ROUND);
      rsh  = rsum >> ANG_SHIFT;
      if (en) begin
         angle_ff <= (rsh > (XY_BITS+1)'({ANGLE_BITS{1'b1}})) ? '1 : rsh[ANGLE_BITS-1:0];
      end
   end

   assign angle = angle_ff;

endmodule

// File: hw/rtl/tcaa_back.sv
// Back end: three angle lanes fed from the queue, with the result word register.
module tcaa_back import tcaa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_stat,
   input  tri_type          head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_word
);

   logic                  vld_ff [0:ANGLE_LAT-1];
   logic                  ok_ff  [0:ANGLE_LAT-1];
   logic                  adv;
   logic [ANGLE_BITS-1:0] ang_a, ang_b, ang_c;

   assign adv       = !(vld_ff[ANGLE_LAT-1] && rsp_stall);
   assign pop       = adv && !q_stat.empty;
   assign rsp_valid = vld_ff[ANGLE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < ANGLE_LAT; n++) begin
            vld_ff[n] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= pop;
         for (int n = 1; n < ANGLE_LAT; n++) begin
            vld_ff[n] <= vld_ff[n-1];
         end
      end
      if (adv) begin
         ok_ff[0] <= head.ok;
         for (int n = 1; n < ANGLE_LAT; n++) begin
            ok_ff[n] <= ok_ff[n-1];
         end
      end
   end

   tcaa_angle u_lane_a (
      .clock(clock), .en(adv), .s(head.a), .p(head.b), .q(head.c), .angle(ang_a));
   tcaa_angle u_lane_b (
      .clock(clock), .en(adv), .s(head.b), .p(head.a), .q(head.c), .angle(ang_b));
   tcaa_angle u_lane_c (
      .clock(clock), .en(adv), .s(head.c), .p(head.a), .q(head.b), .angle(ang_c));

   always_comb begin
      rsp_word.valid_res = ok_ff[ANGLE_LAT-1];
      rsp_word.angle_a   = ok_ff[ANGLE_LAT-1] ? ang_a : '0;
      rsp_word.angle_b   = ok_ff[ANGLE_LAT-1] ? ang_b : '0;
      rsp_word.angle_c   = ok_ff[ANGLE_LAT-1] ? ang_c : '0;
   end

endmodule

// File: hw/rtl/triangle_check_and_angles_top.sv
// Top level of the triangle check and interior angle engine.
//
// Each request word carries three signed Q8.8 side lengths. The block flags
// the triangle valid when every side is nonnegative and each side is strictly
// shorter than the sum of the other two, and for a valid triangle returns the
// three interior angles in radians as unsigned Q2.14, each angle facing the
// side of the same letter; an invalid triangle returns zero angles. The block
// takes one word per cycle while req_stall is low and returns one response
// word per request in order. A word passes through the front register, the
// queue and the angle pipeline in turn; the depth of that pipeline comes
// mostly from the per-bit cosine divider (30 stages), the square root for
// the sine (31 stages) and the CORDIC arc tangent (32 stages). A stall on
// the response side, with a response waiting, freezes the pipeline while the
// four-entry queue and the front register keep taking words until they fill.
module triangle_check_and_angles_top import tcaa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   queue_status_type q_stat;
   tri_type          push_ent, head;
   logic             push, pop;

   // The front end checks the sides and parks the classified word.
   tcaa_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .q_stat(q_stat), .push(push), .push_ent(push_ent));

   // The queue lets the front end keep accepting while the back end is held.
   tcaa_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_ent(push_ent), .pop(pop), .head(head), .q_stat(q_stat));

   // The back end computes the three angles and holds the response word.
   tcaa_back u_back (
      .clock(clock), .reset(reset),
      .q_stat(q_stat), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word));

endmodule

// File: tb/tb.sv
// Self-checking testbench for the triangle check and interior angle engine.
module tb import tcaa_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // Scoreboard: computes the expected angles for every accepted request
   // word and compares returned response words against them in order.
   class triangle_scoreboard;
      rsp_word_type expected_angles[$];
      longint       atan_table[CORDIC_STEPS];
      longint       pi_fixed;
      int           mismatches;

      function new();
         longint quarter;
         quarter = 4 * atan_of_recip(5) - atan_of_recip(239);
         atan_table[0] = (quarter + (64'sd1 <<< 29)) >>> 30;
         for (int i = 1; i < CORDIC_STEPS; i++)
            atan_table[i] = (atan_of_recip(64'd1 << i) + (64'sd1 <<< 29)) >>> 30;
         pi_fixed = (quarter + (64'sd1 <<< 27)) >>> 28;
         mismatches = 0;
      endfunction

      // Arc tangent of 1/n in Q60 by its alternating power series.
      function longint atan_of_recip(longint unsigned n);
         longint unsigned n_sq, pw, k;
         longint sum, term;
         n_sq = n * n;
         pw   = (64'd1 << 60) / n;
         k    = 0;
         sum  = 0;
         while (pw != 0) begin
            term = longint'(pw / (2 * k + 1));
            if (k[0] == 1'b0) sum += term;
            else sum -= term;
            pw = pw / n_sq;
            k++;
         end
         return sum;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v    = v - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      // Shift of a signed value that truncates toward zero.
      function longint shift_toward_zero(longint v, int s);
         longint unsigned m;
         if (v >= 0) return v >>> s;
         m = 64'd0 - longint'(v);
         return -longint'(m >> s);
      endfunction

      // Angle facing side s, between sides p and q (all positive).
      function logic [ANGLE_BITS-1:0] angle_facing(longint s, longint p, longint q);
         longint          num, x, y, z, ang, xs, ys;
         longint unsigned den, mag, cosv, rem, r;
         bit              obtuse;
         num    = p * p + q * q - s * s;
         den    = 2 * longint'(p) * longint'(q);
         obtuse = num < 0;
         mag    = obtuse ? 64'd0 - num : num;
         if (mag >= den) begin
            cosv = 64'd1 << 30;
         end else begin
            rem  = mag;
            cosv = 0;
            for (int i = 0; i < 30; i++) begin
               rem  = rem << 1;
               cosv = cosv << 1;
               if (rem >= den) begin
                  rem  = rem - den;
                  cosv = cosv | 1;
               end
            end
            if (2 * rem >= den) cosv++;
         end
         x = longint'(cosv);
         y = longint'(int_sqrt((64'd1 << 60) - cosv * cosv));
         z = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = shift_toward_zero(x, i);
            ys = shift_toward_zero(y, i);
            if (y > 0) begin
               x += ys;
               y -= xs;
               z += atan_table[i];
            end else begin
               x -= ys;
               y += xs;
               z -= atan_table[i];
            end
         end
         ang = obtuse ? pi_fixed - z : z;
         if (ang < 0) ang = 0;
         if (ang > pi_fixed) ang = pi_fixed;
         r = (longint'(ang) + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
         if (r > 64'hFFFF) r = 64'hFFFF;
         return r[ANGLE_BITS-1:0];
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type e;
         longint       a, b, c;
         a = w.side_a;
         b = w.side_b;
         c = w.side_c;
         e = '0;
         if (a >= 0 && b >= 0 && c >= 0 && a + b > c && a + c > b && b + c > a) begin
            e.valid_res = 1'b1;
            e.angle_a   = angle_facing(a, b, c);
            e.angle_b   = angle_facing(b, a, c);
            e.angle_c   = angle_facing(c, a, b);
         end
         expected_angles.push_back(e);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type e;
         if (expected_angles.size() == 0) begin
            report_mismatch("response with nothing expected", '0, got);
            return;
         end
         e = expected_angles.pop_front();
         if (got.valid_res !== e.valid_res || got.angle_a !== e.angle_a ||
             got.angle_b !== e.angle_b || got.angle_c !== e.angle_c)
            report_mismatch("response word differs", e, got);
      endfunction

      function void report_mismatch(string what, rsp_word_type e, rsp_word_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH %s: expected ok=%0b a=%0d b=%0d c=%0d, got ok=%0b a=%0d b=%0d c=%0d",
                     what, e.valid_res, e.angle_a, e.angle_b, e.angle_c,
                     got.valid_res, got.angle_a, got.angle_b, got.angle_c);
      endfunction

      function int pending();
         return expected_angles.size();
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   triangle_scoreboard scoreboard;

   // When set, the sender drives back-to-back words with no idle cycles.
   bit sender_burst;
   bit receiver_burst;

   triangle_check_and_angles_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sends one request word after a random number of idle cycles. The task
   // returns in the time step of the edge that accepted the word, so the
   // next call can either keep valid high or drop it with a single update.
   task automatic send_word(input req_word_type w);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      scoreboard.note_request(w);
   endtask

   task automatic send_sides(input int a, input int b, input int c);
      req_word_type w;
      w.side_a = a[SIDE_BITS-1:0];
      w.side_b = b[SIDE_BITS-1:0];
      w.side_c = c[SIDE_BITS-1:0];
      send_word(w);
   endtask

   // Random triangle, mostly well formed; the third side lands on a random
   // position so every angle output sees obtuse and acute cases.
   task automatic send_random_triangle();
      int b, c, lo, hi, a, kind, top, pos;
      kind = $urandom_range(0, 99);
      top  = ($urandom_range(0, 2) == 0) ? 255 : 32767;
      b    = $urandom_range(1, top);
      c    = $urandom_range(1, top);
      lo   = (b > c ? b - c : c - b) + 1;
      hi   = (b + c - 1 > 32767) ? 32767 : b + c - 1;
      if (kind < 70) begin
         a = $urandom_range(lo, hi);
      end else if (kind < 80) begin
         // Degenerate: one side equals the sum of the other two.
         a = ($urandom_range(0, 1) == 0) ? lo - 1 : hi + 1;
         if (a > 32767) a = lo - 1;
      end else begin
         a = $urandom_range(0, 65535);
         b = $urandom_range(0, 65535);
         c = $urandom_range(0, 65535);
      end
      pos = $urandom_range(0, 2);
      if (pos == 0) send_sides(a, b, c);
      else if (pos == 1) send_sides(b, a, c);
      else send_sides(b, c, a);
   endtask

   // Stimulus: directed corners first, then the random body.
   initial begin
      scoreboard     = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_word       = '0;
      sender_burst   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sides(0, 0, 0);
      send_sides(-32768, -32768, -32768);
      send_sides(32767, 32767, 32767);
      send_sides(-1, 5, 5);
      send_sides(5, -1, 5);
      send_sides(5, 5, -32768);
      send_sides(0, 5, 5);
      send_sides(10, 4, 6);
      send_sides(4, 10, 6);
      send_sides(4, 6, 10);
      send_sides(1, 1, 1);
      send_sides(256, 256, 256);
      send_sides(768, 1024, 1280);
      send_sides(1, 32767, 32767);
      send_sides(32767, 1, 32767);
      send_sides(32767, 16384, 16384);
      send_sides(16384, 32767, 16384);
      send_sides(16384, 16384, 32767);
      send_sides(32767, 16383, 16384);
      send_sides(2, 1, 1);
      send_sides(3, 2, 2);

      for (int n = 0; n < 1750; n++) begin
         if (n % 120 == 0) sender_burst = ($urandom_range(0, 2) == 0);
         if (n == 900) begin
            // Hold off until every outstanding response has drained.
            req_valid <= 1'b0;
            while (scoreboard.pending() != 0) @(posedge clock);
         end
         send_random_triangle();
      end
      req_valid <= 1'b0;

      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Response side: random stall before each word, with burst stretches.
   initial begin
      int hold;
      int count;
      rsp_stall      = 1'b0;
      receiver_burst = 1'b0;
      count          = 0;
      @(negedge reset);
      forever begin
         if (count % 150 == 0) receiver_burst = ($urandom_range(0, 2) == 0);
         count++;
         hold = receiver_burst ? 0 : $urandom_range(0, 19);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         scoreboard.check_response(rsp_word);
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/tcaa_pkg.sv
hw/rtl/tcaa_front.sv
hw/rtl/tcaa_queue.sv
hw/rtl/tcaa_angle.sv
hw/rtl/tcaa_back.sv
hw/rtl/triangle_check_and_angles_top.sv
tb/tb.sv
